// File: src/ctb_pkg.sv
// Shared types and constants for the circular trace buffer.
// Used by ctb_ring and circular_trace_buffer_unit; depends on nothing.
`default_nettype none

package ctb_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int CFG_W         = 7;
  localparam int FILL_W        = 7;

  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  typedef enum logic [1:0] {
    OP_RECORD     = 2'd0,
    OP_READ_ALL   = 2'd1,
    OP_READ_FRAME = 2'd2,
    OP_READ_CORR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] frame;
    logic [31:0] correlation;
    logic [31:0] event_payload;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] entry_frame;
    logic [31:0] entry_correlation;
    logic [31:0] entry_payload;
    logic [63:0] entry_sequence;
    logic        last;
    fill_t       fill_count;
    logic [63:0] overwrite_count;
  } out_item_t;

  // One stored trace entry.
  typedef struct packed {
    logic [63:0] frame;
    logic [31:0] correlation;
    logic [31:0] payload;
    logic [63:0] seq_no;
  } entry_t;

endpackage

`default_nettype wire

// File: src/ctb_ring.sv
// Entry storage for the trace ring: one write port, one registered read port.
// Depends on ctb_pkg for the entry type.
`default_nettype none

module ctb_ring #(
  parameter int DEPTH = ctb_pkg::DEPTH_DEFAULT,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire ctb_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output ctb_pkg::entry_t      rd_data
);

  ctb_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/circular_trace_buffer_unit.sv
// Circular trace buffer top level: sequencer, counters and output register.
// Depends on ctb_pkg and ctb_ring.
//
// Channels: in_valid/in_ready/in_data carries record and read transactions,
// out_valid/out_ready/out_data carries results, cfg_valid/cfg_ready/cfg_data
// writes the ring capacity (0 acts as 1, above DEPTH acts as DEPTH) and
// clears the ring, the sequence stamp and the overwrite count.
// A record gives no result; in_ready stays high after it.
// A read scans the retained entries oldest first through the single read port
// of the entry memory, one entry per cycle while the receiver does not stall,
// each compared against the key by one comparator. The scan holds in_ready
// low until it ends. A match is held back until the next one shows whether
// it is the last, so a result is loaded as the next match is compared, the
// final one as the scan ends. A read that matches nothing gives one result
// with found 0. When the receiver stalls, the scan holds at the first match
// that cannot move on and resumes when out_ready returns. A finished result
// may wait in the output register while the next transaction is accepted.
// Reset (rst, synchronous) empties the ring, sets the capacity to DEPTH and
// clears all counters; entry storage is not cleared.
`default_nettype none

module circular_trace_buffer_unit #(
  parameter int DEPTH = ctb_pkg::DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ctb_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ctb_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire ctb_pkg::cfg_t     cfg_data
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cap;
  logic [IDX_W-1:0]   wslot;
  logic [CNT_W-1:0]   held;
  logic [63:0]        stamp;
  logic [63:0]        lost;
  logic [IDX_W-1:0]   scan_slot;
  logic [CNT_W-1:0]   scan_left;
  ctb_pkg::op_t       scan_op;
  logic [63:0]        key_frame;
  logic [31:0]        key_corr;
  logic               rvalid;
  logic               pend_valid;
  ctb_pkg::entry_t    pend;

  logic               in_fire;
  logic               cfg_fire;
  logic               out_free;
  logic               match;
  logic               stall;
  logic               issue;
  logic               finish;
  logic               push_pend;
  logic               out_load;
  ctb_pkg::out_item_t out_load_data;
  logic               rec_en;
  ctb_pkg::entry_t    wr_entry;
  ctb_pkg::entry_t    rd_entry;
  logic [CNT_W-1:0]   wslot_inc;
  logic [CNT_W-1:0]   scan_inc;
  logic [CNT_W-1:0]   cap_next;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || out_ready;
  assign rec_en    = in_fire && (in_data.op == ctb_pkg::OP_RECORD);

  assign wr_entry.frame       = in_data.frame;
  assign wr_entry.correlation = in_data.correlation;
  assign wr_entry.payload     = in_data.event_payload;
  assign wr_entry.seq_no      = stamp;

  ctb_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (rec_en),
    .wr_addr (wslot),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (scan_slot),
    .rd_data (rd_entry)
  );

  // Key compare on the entry held in the ring's read register.
  always_comb begin
    case (scan_op)
      ctb_pkg::OP_READ_ALL:   match = 1'b1;
      ctb_pkg::OP_READ_FRAME: match = (rd_entry.frame == key_frame);
      ctb_pkg::OP_READ_CORR:  match = (rd_entry.correlation == key_corr);
      default:                match = 1'b0;
    endcase
  end

  assign push_pend = rvalid && match && pend_valid;
  assign stall     = push_pend && !out_free;
  assign issue     = (state == S_SCAN) && (scan_left != '0) && !stall;
  assign finish    = (state == S_SCAN) && (scan_left == '0) && !rvalid && out_free;

  assign wslot_inc = CNT_W'(wslot) + CNT_W'(1);
  assign scan_inc  = CNT_W'(scan_slot) + CNT_W'(1);

  always_comb begin
    if (cfg_data == '0) begin
      cap_next = CNT_W'(1);
    end else if (cfg_data > ctb_pkg::CFG_W'(DEPTH)) begin
      cap_next = CNT_W'(DEPTH);
    end else begin
      cap_next = CNT_W'(cfg_data);
    end
  end

  // Output load: move the held match on when a newer one arrives, and close
  // the run with last set when the scan is over.
  always_comb begin
    out_load                          = 1'b0;
    out_load_data.found               = pend_valid;
    out_load_data.entry_frame         = pend_valid ? pend.frame : '0;
    out_load_data.entry_correlation   = pend_valid ? pend.correlation : '0;
    out_load_data.entry_payload       = pend_valid ? pend.payload : '0;
    out_load_data.entry_sequence      = pend_valid ? pend.seq_no : '0;
    out_load_data.last                = 1'b1;
    out_load_data.fill_count          = ctb_pkg::fill_t'(held);
    out_load_data.overwrite_count     = lost;
    if (push_pend && out_free) begin
      out_load           = 1'b1;
      out_load_data.last = 1'b0;
    end else if (finish) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cap        <= CNT_W'(DEPTH);
      wslot      <= '0;
      held       <= '0;
      stamp      <= '0;
      lost       <= '0;
      scan_left  <= '0;
      rvalid     <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_fire) begin
        cap   <= cap_next;
        wslot <= '0;
        held  <= '0;
        stamp <= '0;
        lost  <= '0;
      end else if (rec_en) begin
        stamp <= stamp + 64'd1;
        wslot <= (wslot_inc >= cap) ? '0 : IDX_W'(wslot_inc);
        if (held < cap) begin
          held <= held + CNT_W'(1);
        end else begin
          lost <= lost + 64'd1;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_fire && (in_data.op != ctb_pkg::OP_RECORD)) begin
            state     <= S_SCAN;
            scan_left <= held;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_left <= scan_left - CNT_W'(1);
          end
          if (!stall) begin
            rvalid <= issue;
          end
          if (rvalid && match && !stall) begin
            pend_valid <= 1'b1;
          end
          if (finish) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scan_op   <= in_data.op;
      key_frame <= in_data.frame;
      key_corr  <= in_data.correlation;
      scan_slot <= (held == cap) ? wslot : '0;
    end else if (issue) begin
      scan_slot <= (scan_inc >= cap) ? '0 : IDX_W'(scan_inc);
    end
    if (rvalid && match && !stall) begin
      pend <= rd_entry;
    end
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

endmodule

`default_nettype wire

// File: test/ctb_trace_checker.sv
// Result checker for circular_trace_buffer_unit: mirrors the ring from the
// accepted record, read and capacity transactions and compares every result.
// Depends on ctb_pkg.

module ctb_trace_checker #(
  parameter int RING_DEPTH = ctb_pkg::DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire ctb_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire ctb_pkg::out_item_t out_data,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire ctb_pkg::cfg_t      cfg_data,
  input  wire logic               end_check,
  output int                      fail_count,
  output int                      results_owed
);

  logic [63:0] ring_frame   [RING_DEPTH];
  logic [31:0] ring_corr    [RING_DEPTH];
  logic [31:0] ring_payload [RING_DEPTH];
  logic [63:0] ring_stamp   [RING_DEPTH];

  int unsigned ring_cap;
  int unsigned write_pos;
  int unsigned held;
  logic [63:0] next_seq;
  logic [63:0] lost;

  ctb_pkg::out_item_t results_due[$];
  int unsigned        result_no;
  bit                 leftovers_done;

  initial begin
    fail_count     = 0;
    results_owed   = 0;
    result_no      = 0;
    leftovers_done = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("trace check: result %0d %s: got %h want %h", result_no, what, got, want);
    fail_count++;
  endtask

  task automatic clear_ring();
    write_pos = 0;
    held      = 0;
    next_seq  = '0;
    lost      = '0;
  endtask

  // Zero acts as one and capacities above the ring size clamp to it; any write empties the ring.
  task automatic set_capacity(input ctb_pkg::cfg_t value);
    if (value == 0)
      ring_cap = 1;
    else if (value > RING_DEPTH)
      ring_cap = RING_DEPTH;
    else
      ring_cap = value;
    clear_ring();
  endtask

  function automatic ctb_pkg::out_item_t status_only();
    ctb_pkg::out_item_t r;
    r                 = '0;
    r.fill_count      = ctb_pkg::fill_t'(held);
    r.overwrite_count = lost;
    return r;
  endfunction

  task automatic predict_trace_op(input ctb_pkg::in_item_t item);
    int unsigned        first;
    int unsigned        slot;
    int unsigned        hits;
    logic               hit;
    ctb_pkg::out_item_t r;
    if (item.op == ctb_pkg::OP_RECORD) begin
      slot               = write_pos;
      ring_frame[slot]   = item.frame;
      ring_corr[slot]    = item.correlation;
      ring_payload[slot] = item.event_payload;
      ring_stamp[slot]   = next_seq;
      next_seq           = next_seq + 64'd1;
      write_pos          = (slot + 1 >= ring_cap) ? 0 : slot + 1;
      if (held < ring_cap)
        held++;
      else
        lost = lost + 64'd1;
    end else begin
      // Oldest entry sits at the write position once the ring has wrapped.
      first = (held == ring_cap) ? write_pos : 0;
      hits  = 0;
      for (int unsigned k = 0; k < held; k++) begin
        slot = first + k;
        if (slot >= ring_cap)
          slot -= ring_cap;
        case (item.op)
          ctb_pkg::OP_READ_ALL:   hit = 1'b1;
          ctb_pkg::OP_READ_FRAME: hit = (ring_frame[slot] == item.frame);
          default:                hit = (ring_corr[slot] == item.correlation);
        endcase
        if (hit) begin
          r                   = status_only();
          r.found             = 1'b1;
          r.entry_frame       = ring_frame[slot];
          r.entry_correlation = ring_corr[slot];
          r.entry_payload     = ring_payload[slot];
          r.entry_sequence    = ring_stamp[slot];
          results_due.insert(results_due.size(), r);
          hits++;
        end
      end
      if (hits == 0) begin
        r      = status_only();
        r.last = 1'b1;
        results_due.insert(results_due.size(), r);
      end else begin
        r      = results_due[results_due.size() - 1];
        r.last = 1'b1;
        results_due[results_due.size() - 1] = r;
      end
    end
  endtask

  task automatic check_result(input ctb_pkg::out_item_t got);
    ctb_pkg::out_item_t want;
    if (results_due.size() == 0) begin
      flag_mismatch("arrived with nothing owed", got.found, 1'b0);
    end else begin
      want = results_due.pop_front();
      if (got.found !== want.found)
        flag_mismatch("found", got.found, want.found);
      if (got.entry_frame !== want.entry_frame)
        flag_mismatch("entry_frame", got.entry_frame, want.entry_frame);
      if (got.entry_correlation !== want.entry_correlation)
        flag_mismatch("entry_correlation", got.entry_correlation, want.entry_correlation);
      if (got.entry_payload !== want.entry_payload)
        flag_mismatch("entry_payload", got.entry_payload, want.entry_payload);
      if (got.entry_sequence !== want.entry_sequence)
        flag_mismatch("entry_sequence", got.entry_sequence, want.entry_sequence);
      if (got.last !== want.last)
        flag_mismatch("last", got.last, want.last);
      if (got.fill_count !== want.fill_count)
        flag_mismatch("fill_count", got.fill_count, want.fill_count);
      if (got.overwrite_count !== want.overwrite_count)
        flag_mismatch("overwrite_count", got.overwrite_count, want.overwrite_count);
    end
    result_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ring_cap = RING_DEPTH;
      clear_ring();
      results_due.delete();
    end else begin
      // Retire results before predicting: a result never belongs to a
      // transaction accepted on the same edge.
      if (out_valid && out_ready)
        check_result(out_data);
      if (cfg_valid && cfg_ready)
        set_capacity(cfg_data);
      if (in_valid && in_ready)
        predict_trace_op(in_data);
      if (end_check && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (results_due.size() != 0)
          flag_mismatch("results never delivered", results_due.size(), 0);
      end
    end
    results_owed <= results_due.size();
  end

endmodule

// File: test/tb_circular_trace_buffer_unit.sv
// Testbench top for circular_trace_buffer_unit: drives records, reads and
// capacity writes with random idling and gives the verdict.
// Depends on ctb_pkg, circular_trace_buffer_unit and ctb_trace_checker.

module tb_circular_trace_buffer_unit;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  ctb_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ctb_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  ctb_pkg::cfg_t      cfg_data;
  logic               end_check;

  int fail_count;
  int results_owed;

  logic quiet;
  logic hold_request;
  logic long_hold;
  int   rx_stall    = 0;
  int   cycle_count = 0;

  logic [63:0] frame_keys [4];
  logic [31:0] corr_keys  [4];

  circular_trace_buffer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ctb_trace_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .end_check    (end_check),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall bursts, plus the one long hold-off.
  always @(posedge clk) begin
    if (rx_stall != 0)
      rx_stall = rx_stall - 1;
    else if (!quiet && $urandom_range(0, 11) == 0)
      rx_stall = $urandom_range(1, 18);
    out_ready <= !long_hold && (rx_stall == 0);
  end

  initial begin
    long_hold = 1'b0;
    @(posedge clk);
    while (!hold_request) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input ctb_pkg::op_t op, input logic [63:0] frame,
                           input logic [31:0] corr, input logic [31:0] payload);
    ctb_pkg::in_item_t item;
    int                gap;
    item.op            = op;
    item.frame         = frame;
    item.correlation   = corr;
    item.event_payload = payload;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender until every owed result is out, then let a scan settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(input ctb_pkg::cfg_t value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_trace_op(input int record_pct);
    ctb_pkg::op_t op;
    logic [63:0]  frame;
    logic [31:0]  corr;
    frame = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                        : frame_keys[$urandom_range(0, 3)];
    corr  = ($urandom_range(0, 3) == 0) ? $urandom : corr_keys[$urandom_range(0, 3)];
    if ($urandom_range(0, 99) < record_pct)
      op = ctb_pkg::OP_RECORD;
    else
      case ($urandom_range(0, 2))
        0:       op = ctb_pkg::OP_READ_ALL;
        1:       op = ctb_pkg::OP_READ_FRAME;
        default: op = ctb_pkg::OP_READ_CORR;
      endcase
    send_item(op, frame, corr, $urandom);
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    end_check    = 1'b0;
    frame_keys[0] = '0;
    frame_keys[1] = '1;
    frame_keys[2] = {$urandom, $urandom};
    frame_keys[3] = {$urandom, $urandom};
    corr_keys[0]  = '0;
    corr_keys[1]  = '1;
    corr_keys[2]  = $urandom;
    corr_keys[3]  = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty ring: every read answers not-found.
    send_item(ctb_pkg::OP_READ_ALL, '0, '0, '0);
    send_item(ctb_pkg::OP_READ_FRAME, '0, '0, '0);
    send_item(ctb_pkg::OP_READ_CORR, '1, '1, '1);
    // Field extremes, then matching and non-matching keys.
    send_item(ctb_pkg::OP_RECORD, '0, '0, '0);
    send_item(ctb_pkg::OP_RECORD, '1, '1, '1);
    send_item(ctb_pkg::OP_RECORD, 64'h0123_4567_89ab_cdef, '1, 32'h5a5a_a5a5);
    send_item(ctb_pkg::OP_READ_ALL, '0, '0, '0);
    send_item(ctb_pkg::OP_READ_FRAME, '1, '0, '0);
    send_item(ctb_pkg::OP_READ_FRAME, '0, '0, '0);
    send_item(ctb_pkg::OP_READ_FRAME, 64'd777, '0, '0);
    send_item(ctb_pkg::OP_READ_CORR, '0, '1, '0);
    send_item(ctb_pkg::OP_READ_CORR, '0, 32'd5, '0);

    // Capacity of one: each record after the first overwrites.
    write_depth(ctb_pkg::cfg_t'(1));
    send_item(ctb_pkg::OP_RECORD, 64'd10, 32'd1, 32'd100);
    send_item(ctb_pkg::OP_RECORD, 64'd11, 32'd2, 32'd101);
    send_item(ctb_pkg::OP_RECORD, 64'd12, 32'd3, 32'd102);
    send_item(ctb_pkg::OP_READ_ALL, '0, '0, '0);
    send_item(ctb_pkg::OP_READ_FRAME, 64'd10, '0, '0);
    send_item(ctb_pkg::OP_READ_CORR, '0, 32'd3, '0);

    // Zero acts as one.
    write_depth('0);
    send_item(ctb_pkg::OP_RECORD, '1, '0, '1);
    send_item(ctb_pkg::OP_RECORD, '0, '1, '0);
    send_item(ctb_pkg::OP_READ_ALL, '0, '0, '0);

    // Above the ring size acts as the full ring; fill past it to wrap.
    write_depth('1);
    for (int i = 0; i < 68; i++)
      random_trace_op(100);
    hold_request <= 1'b1;
    send_item(ctb_pkg::OP_READ_ALL, '0, '0, '0);
    send_item(ctb_pkg::OP_READ_FRAME, frame_keys[$urandom_range(0, 3)], '0, '0);
    send_item(ctb_pkg::OP_READ_CORR, '0, corr_keys[$urandom_range(0, 3)], '0);

    write_depth(ctb_pkg::cfg_t'(2));
    for (int i = 0; i < 8; i++)
      random_trace_op(60);

    write_depth(ctb_pkg::cfg_t'(64));
    for (int i = 0; i < 4; i++)
      random_trace_op(70);

    // Closing stretch runs without idling on either side.
    write_depth(ctb_pkg::cfg_t'($urandom_range(3, 8)));
    quiet = 1'b1;
    for (int i = 0; i < 8; i++)
      random_trace_op(60);

    drain();
    end_check <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: circular_trace_buffer_unit.f
src/ctb_pkg.sv
src/ctb_ring.sv
src/circular_trace_buffer_unit.sv
test/ctb_trace_checker.sv
test/tb_circular_trace_buffer_unit.sv
